[rtl/lbs_pkg.sv]
// Shared types and constants for the linear blend skinning unit.
// Depends on nothing; every module of the unit imports it.
package lbs_pkg;
  localparam int BoneCount = 64;
  localparam int FracBits  = 16;
  localparam int BoneW     = 6;
  localparam int SlotCount = 12;
  localparam int MemDepth  = BoneCount * SlotCount;
  localparam int AddrW     = $clog2(MemDepth);
  localparam int AccW      = 48;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_INFLUENCE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [5:0]         bone_index;
    logic [3:0]         matrix_slot;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nor_x;
    logic signed [31:0] nor_y;
    logic signed [31:0] nor_z;
    logic [16:0]        weight;
    logic               last_influence;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_nor_x;
    logic signed [31:0] out_nor_y;
    logic signed [31:0] out_nor_z;
  } out_item_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic               use_bone;
    logic               last;
    logic [BoneW-1:0]   bone;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nor_x;
    logic signed [31:0] nor_y;
    logic signed [31:0] nor_z;
    logic [16:0]        weight;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [31:0]      data;
  } mem_wr_t;

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW+1:0] x);
    logic signed [AccW+1:0] hi;
    logic signed [AccW+1:0] lo;
    hi = {3'b000, {(AccW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) return hi[AccW-1:0];
    else if (x < lo) return lo[AccW-1:0];
    else return x[AccW-1:0];
  endfunction
endpackage

[rtl/lbs_front.sv]
// Front end: accepts items, writes matrix loads, queues influence jobs.
// Depends on lbs_pkg.
module lbs_front import lbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  input  logic     enable,
  output mem_wr_t  mem_wr,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_pop,
  input  logic     back_busy
);
  localparam int QDepth = 2;

  job_t       q [QDepth];
  logic [0:0] wp;
  logic [0:0] rp;
  logic [1:0] cnt;
  logic       accept;
  logic       is_job;
  logic       in_range;

  // A load waits until every earlier influence has finished with the matrix table.
  assign full      = (cnt == 2'(QDepth))
                     || ((in_item.opcode == OP_LOAD) && (job_valid || back_busy));
  assign accept    = push && !full;
  assign in_range  = (32'(in_item.bone_index) < 32'(BoneCount));
  assign is_job    = accept && (in_item.opcode == OP_INFLUENCE) && enable;
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  always_comb begin
    mem_wr.we   = accept && (in_item.opcode == OP_LOAD) && in_range
                  && (in_item.matrix_slot < 4'(SlotCount));
    mem_wr.addr = AddrW'(32'(in_item.bone_index) * SlotCount + 32'(in_item.matrix_slot));
    mem_wr.data = in_item.matrix_value;
  end

  always_ff @(posedge clk) begin
    if (is_job) begin
      q[wp].use_bone <= in_range;
      q[wp].last     <= in_item.last_influence;
      q[wp].bone     <= in_item.bone_index;
      q[wp].pos_x    <= in_item.pos_x;
      q[wp].pos_y    <= in_item.pos_y;
      q[wp].pos_z    <= in_item.pos_z;
      q[wp].nor_x    <= in_item.nor_x;
      q[wp].nor_y    <= in_item.nor_y;
      q[wp].nor_z    <= in_item.nor_z;
      q[wp].weight   <= in_item.weight;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (is_job) wp <= wp + 1'b1;
      if (job_pop) rp <= rp + 1'b1;
      cnt <= cnt + 2'(is_job) - 2'(job_pop);
    end
  end
endmodule

[rtl/lbs_back.sv]
// Back end: bone matrix memory, sequenced dot products, weighting and accumulation.
// Depends on lbs_pkg.
module lbs_back import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mem_wr_t   mem_wr,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      back_busy,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_MUL   = 6'b000100,
    S_WGT   = 6'b001000,
    S_ACC   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  logic [31:0] mem [MemDepth];
  logic [31:0] rd_data;
  logic [AddrW-1:0] rd_addr;

  state_t state;
  logic [1:0] row;
  logic [1:0] col;
  logic signed [31:0] m0, m1, m2;
  logic signed [AccW+1:0] tp, tn;
  logic signed [AccW+1:0] wp_r, wn_r;
  logic signed [AccW-1:0] acc [6];
  logic out_full;
  job_t jb;

  always_ff @(posedge clk) begin
    if (mem_wr.we) mem[mem_wr.addr] <= mem_wr.data;
    rd_data <= mem[rd_addr];
  end

  assign rd_addr   = AddrW'(32'(jb.bone) * SlotCount + 32'(row) * 4 + 32'(col));
  assign job_pop   = (state == S_IDLE) && job_valid && !out_full;
  assign back_busy = (state != S_IDLE);
  assign empty     = !out_full;

  function automatic logic signed [AccW+1:0] fshr(input logic signed [63:0] p);
    return (AccW+2)'(p >>> FracBits);
  endfunction

  function automatic logic signed [AccW+1:0] wmul(input logic signed [AccW+1:0] t,
                                                   input logic [16:0] w);
    logic signed [AccW+19:0] p;
    p = t * $signed({1'b0, w});
    return (AccW+2)'(p >>> 16);
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [AccW-1:0] a);
    if (a > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (a < -48'sh0000_8000_0000) return 32'sh8000_0000;
    else return a[31:0];
  endfunction

  // Per row: read four elements, three products with pos and nor, weight, accumulate.
  logic signed [31:0] pv, nv;
  always_comb begin
    case (col)
      2'd0: begin pv = jb.pos_x; nv = jb.nor_x; end
      2'd1: begin pv = jb.pos_y; nv = jb.nor_y; end
      default: begin pv = jb.pos_z; nv = jb.nor_z; end
    endcase
  end

  logic [1:0] pcol;
  logic signed [63:0] pp, pn;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
      for (int i = 0; i < 6; i++) acc[i] <= '0;
    end else begin
      if (out_full && pop) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_pop) begin
            jb  <= job;
            row <= '0;
            col <= '0;
            tp  <= '0;
            tn  <= '0;
            state <= job.use_bone ? S_READ : S_EMIT;
          end
        end
        S_READ: begin
          // Address for col issued this cycle; data next cycle.
          pcol  <= col;
          state <= S_MUL;
        end
        S_MUL: begin
          if (pcol == 2'd3) begin
            tp    <= tp + (AccW+2)'($signed(rd_data));
            state <= S_WGT;
          end else begin
            pp  <= $signed(rd_data) * pv;
            pn  <= $signed(rd_data) * nv;
            col <= col + 2'd1;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          tp    <= tp + fshr(pp);
          tn    <= tn + fshr(pn);
          state <= S_READ;
        end
        S_WGT: begin
          wp_r  <= wmul(tp, jb.weight);
          wn_r  <= wmul(tn, jb.weight);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (jb.use_bone && row != 2'd3) begin
            acc[row]   <= sat_acc((AccW+2)'(acc[row]) + (AccW+2)'(sat_acc(wp_r)));
            acc[3+row] <= sat_acc((AccW+2)'(acc[3+row]) + (AccW+2)'(sat_acc(wn_r)));
            tp  <= '0;
            tn  <= '0;
            col <= '0;
            if (row == 2'd2) row <= 2'd3;
            else begin
              row   <= row + 2'd1;
              state <= S_READ;
            end
          end else if (!jb.last) begin
            state <= S_IDLE;
          end else if (!out_full) begin
            out_item.out_pos_x <= sat_out(acc[0]);
            out_item.out_pos_y <= sat_out(acc[1]);
            out_item.out_pos_z <= sat_out(acc[2]);
            out_item.out_nor_x <= sat_out(acc[3]);
            out_item.out_nor_y <= sat_out(acc[4]);
            out_item.out_nor_z <= sat_out(acc[5]);
            for (int i = 0; i < 6; i++) acc[i] <= '0;
            out_full <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/linear_blend_skinning_unit.sv]
// Linear blend skinning unit: front end, job queue and back end.
// Depends on lbs_pkg, lbs_front and lbs_back.
// An in-range influence occupies the back end from picking up the job, through each of the three
// matrix rows (three reads, products and sums, the translation read, weighting and
// accumulation) on a single pair of multipliers, to a final step to finish.
// Loads are written as soon as accepted but wait until every earlier influence has left the back end,
// so a load never changes a matrix that an earlier request still reads. Influences are
// held up only while the two-entry job queue is full. With skinning disabled,
// influences are dropped at the front.
module linear_blend_skinning_unit import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);
  logic    enable;
  mem_wr_t mem_wr;
  logic    job_valid;
  job_t    job;
  logic    job_pop;
  logic    back_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) enable <= 1'b1;
    else if (cfg_valid && cfg_ready) enable <= cfg_data;
  end

  lbs_front u_front (
    .clk, .rst, .push, .full, .in_item, .enable, .mem_wr,
    .job_valid, .job, .job_pop, .back_busy
  );

  lbs_back u_back (
    .clk, .rst, .mem_wr, .job_valid, .job, .job_pop, .back_busy, .empty, .pop, .out_item
  );
endmodule
